### rtl/gctk_pkg.sv
`timescale 1ns / 1ps

package gctk_pkg;

	// Grid and cell sizing
	localparam int MAX_COLS = 16;
	localparam int MAX_ROWS = 16;
	localparam int MAX_KEEP = 8;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int SLOT_W = $clog2(MAX_KEEP);
	localparam int CELL_W = ROW_W + COL_W;
	localparam int NCELLS = 1 << CELL_W;
	localparam int ADDR_W = CELL_W + SLOT_W;
	localparam int NENTRY = 1 << ADDR_W;
	localparam int CNT_W  = $clog2(MAX_KEEP + 1);

	// Field widths
	localparam int PIX_W      = 12;
	localparam int STR_W      = 16;
	localparam int ID_W       = 16;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int KEEP_W     = 4;
	localparam int GRID_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROP  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PIX_W-1:0]  pos_x;
		logic [PIX_W-1:0]  pos_y;
		logic [STR_W-1:0]  strength;
		logic [ID_W-1:0]   feature_id;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   out_id;
		logic [PIX_W-1:0]  out_x;
		logic [PIX_W-1:0]  out_y;
		logic [STR_W-1:0]  out_strength;
		logic              last;
	} out_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [STR_W-1:0] strength;
		logic [PIX_W-1:0] y;
		logic [PIX_W-1:0] x;
	} entry_t;

	// Effective (clamped) configuration
	typedef struct packed {
		logic [PIX_W-1:0] cw;
		logic [PIX_W-1:0] ch;
		logic [CNT_W-1:0] keep;
		logic [COL_W:0]   cols;
		logic [ROW_W:0]   rows;
	} cfg_t;

endpackage

### rtl/gctk_div.sv
`timescale 1ns / 1ps

module gctk_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gctk_pkg::PIX_W-1:0]   dividend,
	input  logic [gctk_pkg::PIX_W-1:0]   divisor,
	output logic                         done,
	output logic [gctk_pkg::PIX_W-1:0]   quotient
);

	localparam int W   = gctk_pkg::PIX_W;
	localparam int CW  = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/gctk_ctrl.sv
`timescale 1ns / 1ps

module gctk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  gctk_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_stall,
	input  gctk_pkg::in_t   in_data,
	output logic            res_valid,
	output gctk_pkg::out_t  res_data,
	input  logic            res_ready
);

	localparam int COL_W  = gctk_pkg::COL_W;
	localparam int ROW_W  = gctk_pkg::ROW_W;
	localparam int SLOT_W = gctk_pkg::SLOT_W;
	localparam int CELL_W = gctk_pkg::CELL_W;
	localparam int CNT_W  = gctk_pkg::CNT_W;
	localparam int PIX_W  = gctk_pkg::PIX_W;

	typedef enum logic [3:0] {
		IDLE, DIV_X, DIV_Y, FILL_RD, FILL_CHK, FULL_RD, FULL_CHK, INS_RD, INS_CHK,
		WR_NEW, SEEK, SEEK_RD, SEEK_CHK, DATA_RD, DATA_CHK, DONE
	} state_t;

	state_t                state_q;
	gctk_pkg::in_t         item_q;
	gctk_pkg::out_t        res_q;
	logic [CELL_W-1:0]     cell_q;
	logic [COL_W-1:0]      col_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     ins_q;
	logic [CNT_W-1:0]      n_q;
	logic [ROW_W:0]        sk_r_q;
	logic [COL_W:0]        sk_c_q;
	logic                  second_q;
	logic [CELL_W-1:0]     cur_cell_q;
	logic [SLOT_W-1:0]     cur_slot_q;
	logic                  done_q;

	// Fill count memory with per-cell valid bits
	logic [CNT_W-1:0]           fill_mem [gctk_pkg::NCELLS];
	logic [gctk_pkg::NCELLS-1:0] fill_vld_q;
	logic [CNT_W-1:0]           fill_rd_q;
	logic                       fill_vld_rd_q;
	logic                       fill_we;
	logic [CNT_W-1:0]           fill_wdata;
	logic [CNT_W-1:0]           cnt;

	// Feature store
	gctk_pkg::entry_t      store_mem [gctk_pkg::NENTRY];
	gctk_pkg::entry_t      st_rd_q;
	logic                  st_we;
	logic [SLOT_W-1:0]     st_wslot;
	gctk_pkg::entry_t      st_wdata;
	gctk_pkg::entry_t      new_entry;

	logic                  accept;
	logic                  clear_go;
	logic                  div_start;
	logic                  div_done;
	logic [PIX_W-1:0]      div_dvd;
	logic [PIX_W-1:0]      div_dvs;
	logic [PIX_W-1:0]      div_quo;
	logic                  q_col_ok;
	logic                  q_row_ok;
	logic [COL_W:0]        c_next;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE);
	assign clear_go = (state_q == IDLE) && accept && (in_data.kind == gctk_pkg::KIND_CLEAR);

	assign new_entry = '{id: item_q.feature_id, strength: item_q.strength,
		y: item_q.pos_y, x: item_q.pos_x};

	// Shared divider: column first, then row
	assign div_start = ((state_q == IDLE) && accept && (in_data.kind == gctk_pkg::KIND_ADD))
		|| ((state_q == DIV_X) && div_done && q_col_ok);
	assign div_dvd   = (state_q == IDLE) ? in_data.pos_x : item_q.pos_y;
	assign div_dvs   = (state_q == IDLE) ? cfg.cw : cfg.ch;
	assign q_col_ok  = div_quo < PIX_W'(cfg.cols);
	assign q_row_ok  = div_quo < PIX_W'(cfg.rows);

	gctk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Kept count of the cell just read
	assign cnt = !fill_vld_rd_q ? '0 : ((fill_rd_q < cfg.keep) ? fill_rd_q : cfg.keep);

	assign c_next = sk_c_q + 1'b1;

	// Memory write controls
	always_comb begin
		st_we      = 1'b0;
		st_wslot   = ins_q;
		st_wdata   = new_entry;
		fill_we    = 1'b0;
		fill_wdata = n_q;
		case (state_q)
			FULL_CHK: begin
				if (st_rd_q.strength >= item_q.strength) begin
					fill_we = 1'b1;
				end
			end
			INS_CHK: begin
				if (st_rd_q.strength < item_q.strength) begin
					st_we    = 1'b1;
					st_wdata = st_rd_q;
				end
			end
			WR_NEW: begin
				st_we      = 1'b1;
				fill_we    = 1'b1;
				fill_wdata = (n_q < cfg.keep) ? n_q + 1'b1 : cfg.keep;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[cell_q] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[cell_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q    <= '0;
			fill_vld_rd_q <= 1'b0;
		end else begin
			if (clear_go) begin
				fill_vld_q <= '0;
			end else if (fill_we) begin
				fill_vld_q[cell_q] <= 1'b1;
			end
			fill_vld_rd_q <= fill_vld_q[cell_q];
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[{cell_q, st_wslot}] <= st_wdata;
		end
		st_rd_q <= store_mem[{cell_q, slot_q}];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			res_q      <= '0;
			cur_cell_q <= '0;
			cur_slot_q <= '0;
			done_q     <= 1'b0;
			second_q   <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						item_q <= in_data;
						case (in_data.kind)
							gctk_pkg::KIND_ADD: begin
								state_q <= DIV_X;
							end
							gctk_pkg::KIND_READ: begin
								if (done_q) begin
									res_q.status <= gctk_pkg::ST_EMPTY;
									state_q      <= DONE;
								end else begin
									sk_r_q   <= {1'b0, cur_cell_q[CELL_W-1:COL_W]};
									sk_c_q   <= {1'b0, cur_cell_q[COL_W-1:0]};
									slot_q   <= cur_slot_q;
									second_q <= 1'b0;
									state_q  <= SEEK;
								end
							end
							gctk_pkg::KIND_CLEAR: begin
								cur_cell_q <= '0;
								cur_slot_q <= '0;
								done_q     <= 1'b0;
								state_q    <= DONE;
							end
							default: begin
								state_q <= DONE;
							end
						endcase
					end
				end
				DIV_X: begin
					if (div_done) begin
						col_q <= div_quo[COL_W-1:0];
						if (q_col_ok) begin
							state_q <= DIV_Y;
						end else begin
							res_q.status <= gctk_pkg::ST_DROP;
							state_q      <= DONE;
						end
					end
				end
				DIV_Y: begin
					if (div_done) begin
						cell_q <= {div_quo[ROW_W-1:0], col_q};
						if (q_row_ok) begin
							state_q <= FILL_RD;
						end else begin
							res_q.status <= gctk_pkg::ST_DROP;
							state_q      <= DONE;
						end
					end
				end
				FILL_RD: begin
					state_q <= FILL_CHK;
				end
				FILL_CHK: begin
					n_q <= cnt;
					if (cnt < cfg.keep) begin
						ins_q <= cnt[SLOT_W-1:0];
						if (cnt == '0) begin
							state_q <= WR_NEW;
						end else begin
							slot_q  <= SLOT_W'(cnt - 1'b1);
							state_q <= INS_RD;
						end
					end else begin
						slot_q  <= SLOT_W'(cnt - 1'b1);
						state_q <= FULL_RD;
					end
				end
				FULL_RD: begin
					state_q <= FULL_CHK;
				end
				FULL_CHK: begin
					// Drop the newcomer unless it beats the weakest kept one
					if (st_rd_q.strength >= item_q.strength) begin
						state_q <= DONE;
					end else begin
						ins_q <= slot_q;
						if (slot_q == '0) begin
							state_q <= WR_NEW;
						end else begin
							slot_q  <= slot_q - 1'b1;
							state_q <= INS_RD;
						end
					end
				end
				INS_RD: begin
					state_q <= INS_CHK;
				end
				INS_CHK: begin
					// Shift weaker entries down one slot
					if (st_rd_q.strength < item_q.strength) begin
						ins_q <= slot_q;
						if (slot_q == '0) begin
							state_q <= WR_NEW;
						end else begin
							slot_q  <= slot_q - 1'b1;
							state_q <= INS_RD;
						end
					end else begin
						state_q <= WR_NEW;
					end
				end
				WR_NEW: begin
					state_q <= DONE;
				end
				SEEK: begin
					if (sk_r_q >= cfg.rows) begin
						done_q <= 1'b1;
						if (second_q) begin
							res_q.last <= 1'b1;
						end else begin
							res_q.status <= gctk_pkg::ST_EMPTY;
						end
						state_q <= DONE;
					end else if (sk_c_q >= cfg.cols) begin
						sk_r_q <= sk_r_q + 1'b1;
						sk_c_q <= '0;
						slot_q <= '0;
					end else begin
						cell_q  <= {sk_r_q[ROW_W-1:0], sk_c_q[COL_W-1:0]};
						state_q <= SEEK_RD;
					end
				end
				SEEK_RD: begin
					state_q <= SEEK_CHK;
				end
				SEEK_CHK: begin
					if (CNT_W'(slot_q) < cnt) begin
						n_q     <= cnt;
						state_q <= second_q ? DONE : DATA_RD;
					end else begin
						sk_c_q  <= c_next;
						slot_q  <= '0;
						state_q <= SEEK;
					end
				end
				DATA_RD: begin
					state_q <= DATA_CHK;
				end
				DATA_CHK: begin
					res_q.out_id       <= st_rd_q.id;
					res_q.out_x        <= st_rd_q.x;
					res_q.out_y        <= st_rd_q.y;
					res_q.out_strength <= st_rd_q.strength;
					second_q           <= 1'b1;
					// Advance the cursor, then look ahead for a further entry
					if ((CNT_W'(slot_q) + 1'b1) < n_q) begin
						slot_q     <= slot_q + 1'b1;
						cur_slot_q <= slot_q + 1'b1;
						cur_cell_q <= cell_q;
						state_q    <= SEEK;
					end else if (c_next < cfg.cols) begin
						sk_c_q     <= c_next;
						slot_q     <= '0;
						cur_slot_q <= '0;
						cur_cell_q <= {sk_r_q[ROW_W-1:0], c_next[COL_W-1:0]};
						state_q    <= SEEK;
					end else if ((sk_r_q + 1'b1) >= (ROW_W + 1)'(gctk_pkg::MAX_ROWS)) begin
						cur_cell_q <= '0;
						cur_slot_q <= '0;
						done_q     <= 1'b1;
						res_q.last <= 1'b1;
						state_q    <= DONE;
					end else begin
						sk_r_q     <= sk_r_q + 1'b1;
						sk_c_q     <= '0;
						slot_q     <= '0;
						cur_slot_q <= '0;
						cur_cell_q <= {ROW_W'(sk_r_q + 1'b1), COL_W'(0)};
						state_q    <= SEEK;
					end
				end
				DONE: begin
					// Hand off the word and clear it for the next item
					if (res_ready) begin
						res_q   <= '0;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == DONE);
	assign res_data  = res_q;

endmodule

### rtl/grid_cell_top_k_feature_filter.sv
`timescale 1ns / 1ps

// Channel | valid    | stall     | word
// in      | in_valid | in_stall  | in_data  (kind, pos_x, pos_y, strength, feature_id)
// out     | out_valid| out_stall | out_data (status, out_id, out_x, out_y, out_strength, last)
// cfg     | cfg_we   | -         | cfg_index, cfg_data
//
// An add runs the shared divider for the column and then for the row (a column outside
// the grid drops after the first), fetches the fill count, steps through the sorted
// insertion slot by slot and ends with one write. A read scans grid cells and wraps rows,
// over the search for the entry and the look-ahead for last. Clear, unused kinds and reads
// past the end go straight to the result. in_stall holds the next item off until the
// current result is handed off. Reset clears the fill valid bits at once. The output
// register takes no new word while the last result waits on out_stall.

module grid_cell_top_k_feature_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  gctk_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output gctk_pkg::out_t                       out_data,
	input  logic                                 cfg_we,
	input  logic [gctk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gctk_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CNT_W  = gctk_pkg::CNT_W;
	localparam int COL_W  = gctk_pkg::COL_W;
	localparam int ROW_W  = gctk_pkg::ROW_W;

	logic [gctk_pkg::PIX_W-1:0]  cw_q;
	logic [gctk_pkg::PIX_W-1:0]  ch_q;
	logic [gctk_pkg::KEEP_W-1:0] keep_q;
	logic [gctk_pkg::GRID_W-1:0] cols_q;
	logic [gctk_pkg::GRID_W-1:0] rows_q;
	gctk_pkg::cfg_t              cfg;
	logic                        res_valid;
	logic                        res_ready;
	gctk_pkg::out_t              res_data;
	logic                        out_valid_q;
	gctk_pkg::out_t              out_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q   <= gctk_pkg::PIX_W'(32);
			ch_q   <= gctk_pkg::PIX_W'(32);
			keep_q <= gctk_pkg::KEEP_W'(4);
			cols_q <= gctk_pkg::GRID_W'(16);
			rows_q <= gctk_pkg::GRID_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				gctk_pkg::REG_CELL_WIDTH:  cw_q   <= cfg_data;
				gctk_pkg::REG_CELL_HEIGHT: ch_q   <= cfg_data;
				gctk_pkg::REG_KEEP:        keep_q <= cfg_data[gctk_pkg::KEEP_W-1:0];
				gctk_pkg::REG_GRID_COLS:   cols_q <= cfg_data[gctk_pkg::GRID_W-1:0];
				gctk_pkg::REG_GRID_ROWS:   rows_q <= cfg_data[gctk_pkg::GRID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp registers into their working ranges
	always_comb begin
		cfg.cw = (cw_q == '0) ? gctk_pkg::PIX_W'(1) : cw_q;
		cfg.ch = (ch_q == '0) ? gctk_pkg::PIX_W'(1) : ch_q;
		if (keep_q == '0) begin
			cfg.keep = CNT_W'(1);
		end else if (32'(keep_q) > gctk_pkg::MAX_KEEP) begin
			cfg.keep = CNT_W'(gctk_pkg::MAX_KEEP);
		end else begin
			cfg.keep = CNT_W'(keep_q);
		end
		if (cols_q == '0) begin
			cfg.cols = (COL_W + 1)'(1);
		end else if (32'(cols_q) > gctk_pkg::MAX_COLS) begin
			cfg.cols = (COL_W + 1)'(gctk_pkg::MAX_COLS);
		end else begin
			cfg.cols = (COL_W + 1)'(cols_q);
		end
		if (rows_q == '0) begin
			cfg.rows = (ROW_W + 1)'(1);
		end else if (32'(rows_q) > gctk_pkg::MAX_ROWS) begin
			cfg.rows = (ROW_W + 1)'(gctk_pkg::MAX_ROWS);
		end else begin
			cfg.rows = (ROW_W + 1)'(rows_q);
		end
	end

	gctk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	// Output register: take a result whenever the slot is free or draining
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
